/* hw/rtl/mst_pkg.sv */
package mst_pkg;

	localparam int unsigned SLOT_COUNT_DEF = 16;
	localparam int unsigned VALUE_BITS_DEF = 32;

	localparam int unsigned OP_BITS     = 2;
	localparam int unsigned ITEM_BITS   = 32;
	localparam int unsigned STATUS_BITS = 2;
	localparam int unsigned COUNT_BITS  = 5;

	typedef enum logic [OP_BITS-1:0] {
		OP_INSERT   = 2'd0,
		OP_REMOVE   = 2'd1,
		OP_CONTAINS = 2'd2,
		OP_SPARE    = 2'd3
	} op_t;

	typedef enum logic [STATUS_BITS-1:0] {
		ST_OK      = 2'd0,
		ST_DUP     = 2'd1,
		ST_MISSING = 2'd2,
		ST_FULL    = 2'd3
	} status_t;

	typedef struct packed {
		logic [OP_BITS-1:0]   operation;
		logic [ITEM_BITS-1:0] item_value;
	} req_t;

	typedef struct packed {
		logic [STATUS_BITS-1:0] status;
		logic                   found;
		logic [COUNT_BITS-1:0]  member_count;
		logic                   is_empty;
	} rsp_t;

endpackage

/* hw/rtl/membership_set_table_top.sv */
// channel | direction | handshake            | payload
// --------+-----------+----------------------+----------------------------------------
// req     | in        | req_valid, req_stall | operation, item_value
// rsp     | out       | rsp_valid, rsp_stall | status, found, member_count, is_empty
//
// One request per cycle while rsp is not stalled: a transfer lands in the input
// register, the slot compare, lowest-free pick and count update run from it and
// write the result register, so each reply passes through both registers before
// it can move on. The table is updated at the edge that writes the result register,
// so a following request always sees the effect of the last one.
// Reset clears the valid bits, the count and both handshake registers at once.
// A stall on rsp holds the result register; a full input register then stalls req.
module membership_set_table_top #(
	parameter int unsigned SLOT_COUNT = mst_pkg::SLOT_COUNT_DEF,
	parameter int unsigned VALUE_BITS = mst_pkg::VALUE_BITS_DEF
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          req_valid,
	output logic          req_stall,
	input  mst_pkg::req_t req,
	output logic          rsp_valid,
	input  logic          rsp_stall,
	output mst_pkg::rsp_t rsp
);
	import mst_pkg::*;

	localparam int unsigned CNT_W = $clog2(SLOT_COUNT + 1);

	logic                  req_valid_s1;
	req_t                  req_s1;
	logic                  rsp_valid_q;
	rsp_t                  rsp_q;

	logic [VALUE_BITS-1:0] slot_values_q [SLOT_COUNT];
	logic [SLOT_COUNT-1:0] slot_valid_q;
	logic [CNT_W-1:0]      held_count_q;

	logic                  advance;
	logic                  fire;
	logic                  load_s1;
	logic [VALUE_BITS-1:0] value;
	op_t                   op;
	logic [SLOT_COUNT-1:0] hit_vec;
	logic [SLOT_COUNT-1:0] free_vec;
	logic [SLOT_COUNT-1:0] free_pick;
	logic                  present;
	logic                  full;
	logic                  do_insert;
	logic                  do_remove;
	status_t               status;
	logic [CNT_W-1:0]      count_next;

	// Result register free or being drained this cycle.
	assign advance   = !rsp_valid_q || !rsp_stall;
	assign fire      = req_valid_s1 && advance;
	// Input register empty or handing its request on this cycle.
	assign load_s1   = !req_valid_s1 || advance;
	assign req_stall = !load_s1;

	assign value = VALUE_BITS'(req_s1.item_value);
	assign op    = op_t'(req_s1.operation);

	always_comb begin
		for (int i = 0; i < SLOT_COUNT; i++) begin
			hit_vec[i] = slot_valid_q[i] && (slot_values_q[i] == value);
		end
	end

	assign present   = |hit_vec;
	assign free_vec  = ~slot_valid_q;
	assign full      = ~|free_vec;
	// Isolate the lowest free slot.
	assign free_pick = free_vec & (~free_vec + SLOT_COUNT'(1));

	always_comb begin
		do_insert  = 1'b0;
		do_remove  = 1'b0;
		count_next = held_count_q;
		case (op)
			OP_INSERT: begin
				if (present) begin
					status = ST_DUP;
				end else if (full) begin
					status = ST_FULL;
				end else begin
					status     = ST_OK;
					do_insert  = 1'b1;
					count_next = held_count_q + CNT_W'(1);
				end
			end
			OP_REMOVE: begin
				if (present) begin
					status     = ST_OK;
					do_remove  = 1'b1;
					count_next = held_count_q - CNT_W'(1);
				end else begin
					status = ST_MISSING;
				end
			end
			default: begin
				status = present ? ST_OK : ST_MISSING;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			req_valid_s1 <= 1'b0;
		end else if (load_s1) begin
			req_valid_s1 <= req_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (load_s1 && req_valid) begin
			req_s1 <= req;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			slot_valid_q <= '0;
			held_count_q <= '0;
		end else if (fire) begin
			held_count_q <= count_next;
			if (do_insert) begin
				slot_valid_q <= slot_valid_q | free_pick;
			end else if (do_remove) begin
				slot_valid_q <= slot_valid_q & ~hit_vec;
			end
		end
	end

	always_ff @(posedge clk) begin
		for (int i = 0; i < SLOT_COUNT; i++) begin
			if (fire && do_insert && free_pick[i]) begin
				slot_values_q[i] <= value;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (advance) begin
			rsp_valid_q <= req_valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (fire) begin
			rsp_q.status       <= status;
			rsp_q.found        <= present;
			rsp_q.member_count <= COUNT_BITS'(count_next);
			rsp_q.is_empty     <= (count_next == '0);
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

endmodule
